FILE: sv/lrp_pkg.sv
// Package for the LR shift-reduce parse engine: sizes, codes, packed entry types.
// No dependencies.
package lrp_pkg;
    localparam int STATE_COUNT    = 256;
    localparam int SYMBOL_COUNT   = 64;
    localparam int RULE_COUNT     = 256;
    localparam int STACK_DEPTH    = 64;
    localparam int MAX_REDUCTIONS = 32;

    localparam int STW  = 8;   // state field width
    localparam int SYW  = 6;   // symbol field width
    localparam int RLW  = 8;   // rule field width
    localparam int SPW  = $clog2(STACK_DEPTH);
    localparam int CNTW = SPW + 1;
    localparam int REDW = $clog2(MAX_REDUCTIONS + 1);
    localparam int ACT_DEPTH = STATE_COUNT * SYMBOL_COUNT;
    localparam int ACTAW = $clog2(ACT_DEPTH);
    localparam int RULEAW = $clog2(RULE_COUNT);

    localparam logic [1:0] CMD_ACT   = 2'd0;
    localparam logic [1:0] CMD_RULE  = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;
    localparam logic [1:0] CMD_TOKEN = 2'd3;

    localparam logic [2:0] K_SHIFT  = 3'd1;
    localparam logic [2:0] K_REDUCE = 3'd2;
    localparam logic [2:0] K_GOTO   = 3'd3;
    localparam logic [2:0] K_ACCEPT = 3'd4;

    localparam logic [2:0] EV_ACK      = 3'd0;
    localparam logic [2:0] EV_REDUCED  = 3'd1;
    localparam logic [2:0] EV_SHIFTED  = 3'd2;
    localparam logic [2:0] EV_ACCEPTED = 3'd3;
    localparam logic [2:0] EV_SYNTAX   = 3'd4;
    localparam logic [2:0] EV_FAULT    = 3'd5;

    localparam logic [1:0] PS_IDLE = 2'd0;
    localparam logic [1:0] PS_RUN  = 2'd1;
    localparam logic [1:0] PS_DONE = 2'd2;
    localparam logic [1:0] PS_FAIL = 2'd3;

    typedef struct packed {
        logic [2:0]     kind;
        logic [STW-1:0] num;
    } act_ent_t;

    typedef struct packed {
        logic [SYW-1:0] nt;
        logic [3:0]     len;
    } rule_ent_t;

    typedef struct packed {
        logic [2:0]     ev;
        logic [SYW-1:0] nt;
        logic [RLW-1:0] rule;
        logic [STW-1:0] top;
        logic           last;
    } result_t;
endpackage

FILE: sv/lr_shift_reduce_parse_engine.sv
// Top level of the LR shift-reduce parse engine: sequencer plus three RAMs.
// Depends on lrp_pkg and lrp_ram.
//
// Table-driven LR parse driver. Commands arrive one transaction at a time on
// s_axis, with the command code on s_axis_tuser: action-table write,
// rule-table write, start, or token. Each command gives one or more result
// transactions on m_axis. The event code travels on m_axis_tuser, and the
// final result is flagged by m_axis_tlast. Each reduction goes through action
// read, rule read, stack read of the exposed top, goto read, and the hand-off
// of the reduction result. The action table (16384 x 11), rule table
// (256 x 10) and state stack (64 x 8) are synchronous RAMs with registered
// read data, and every lookup goes through them. The top of the stack is
// also held in a register so a push needs no read-back. One item is worked
// on at a time; s_axis_tready is low from acceptance until its last result
// leaves the output register. Tables power up undefined; reading an entry
// never written returns whatever the RAM holds.
module lr_shift_reduce_parse_engine
    import lrp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // table_state[7:0], table_symbol[13:8], entry_kind[16:14],
    // entry_number[24:17], rule_index[32:25], rule_nonterminal[38:33],
    // rule_length[42:39], token_symbol[48:43], token_rejected[49], zero[55:50]
    input  logic [55:0] s_axis_tdata,
    // cmd[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // reduced_nonterminal[5:0], reduced_rule[13:6], top_state[21:14], zero[23:22]
    output logic [23:0] m_axis_tdata,
    // event_res[2:0]
    output logic [2:0]  m_axis_tuser,
    output logic        m_axis_tlast
);
    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ACT  = 3'd1;  // action read in flight
    localparam logic [2:0] S_RULE = 3'd2;  // rule read in flight
    localparam logic [2:0] S_GOTO = 3'd3;  // goto read in flight (after pop)
    localparam logic [2:0] S_TOP  = 3'd4;  // stack read of exposed top
    localparam logic [2:0] S_OUT  = 3'd5;  // result waiting

    logic [2:0]      st_reg, st_next;
    logic [1:0]      ps_reg, ps_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [STW-1:0]  top_reg, top_next;
    logic [REDW-1:0] red_reg, red_next;
    logic [SYW-1:0]  sym_reg;
    act_ent_t        num_hold_reg;  // reduce action being worked on
    rule_ent_t       rent_reg;
    result_t         res_reg, res_next;
    logic            ovalid_reg, ovalid_next;

    // input fields
    logic [1:0]     in_cmd;
    logic [STW-1:0] in_tstate, in_num, in_ridx;
    logic [SYW-1:0] in_tsym, in_rnt, in_sym;
    logic [2:0]     in_kind;
    logic [3:0]     in_rlen;
    logic           in_rej;
    assign in_cmd    = s_axis_tuser;
    assign in_tstate = s_axis_tdata[7:0];
    assign in_tsym   = s_axis_tdata[13:8];
    assign in_kind   = s_axis_tdata[16:14];
    assign in_num    = s_axis_tdata[24:17];
    assign in_ridx   = s_axis_tdata[32:25];
    assign in_rnt    = s_axis_tdata[38:33];
    assign in_rlen   = s_axis_tdata[42:39];
    assign in_sym    = s_axis_tdata[48:43];
    assign in_rej    = s_axis_tdata[49];

    logic s_acc;
    assign s_acc = s_axis_tvalid && s_axis_tready;

    // RAM ports
    logic             act_we, rule_we, stk_we;
    logic [ACTAW-1:0] act_waddr, act_raddr;
    act_ent_t         act_wdata, act_rdata;
    logic [10:0]      act_rraw;
    logic [RULEAW-1:0] rule_raddr;
    rule_ent_t        rule_rdata;
    logic [9:0]       rule_rraw;
    logic [SPW-1:0]   stk_waddr, stk_raddr;
    logic [STW-1:0]   stk_wdata, stk_rdata;

    assign act_we    = s_acc && (in_cmd == CMD_ACT);
    assign act_waddr = {in_tstate, in_tsym};
    assign act_wdata = '{kind: in_kind, num: in_num};
    assign rule_we   = s_acc && (in_cmd == CMD_RULE);
    assign act_rdata  = act_ent_t'(act_rraw);
    assign rule_rdata = rule_ent_t'(rule_rraw);

    lrp_ram #(.WIDTH(11), .DEPTH(ACT_DEPTH)) u_act (
        .aclk(aclk), .we(act_we), .waddr(act_waddr), .wdata(act_wdata),
        .raddr(act_raddr), .rdata(act_rraw)
    );
    lrp_ram #(.WIDTH(10), .DEPTH(RULE_COUNT)) u_rule (
        .aclk(aclk), .we(rule_we), .waddr(in_ridx), .wdata({in_rnt, in_rlen}),
        .raddr(rule_raddr), .rdata(rule_rraw)
    );
    lrp_ram #(.WIDTH(STW), .DEPTH(STACK_DEPTH)) u_stk (
        .aclk(aclk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .raddr(stk_raddr), .rdata(stk_rdata)
    );

    // top state as the model sees it: 0 with an empty stack
    logic [STW-1:0] top_vis;
    assign top_vis = (cnt_reg == '0) ? '0 : top_reg;

    // popped count for the reduction under way
    logic [CNTW-1:0] cnt_pop;
    assign cnt_pop = cnt_reg - CNTW'(rent_reg.len);

    assign s_axis_tready = (st_reg == S_IDLE) && !ovalid_reg;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {2'd0, res_reg.top, res_reg.rule, res_reg.nt};
    assign m_axis_tuser  = res_reg.ev;
    assign m_axis_tlast  = res_reg.last;

    always_comb begin
        st_next     = st_reg;
        ps_next     = ps_reg;
        cnt_next    = cnt_reg;
        top_next    = top_reg;
        red_next    = red_reg;
        res_next    = res_reg;
        ovalid_next = ovalid_reg;
        act_raddr   = {top_reg, sym_reg};
        rule_raddr  = num_hold_reg.num;
        stk_raddr   = SPW'(cnt_pop - 1'b1);
        stk_we      = 1'b0;
        stk_waddr   = SPW'(cnt_reg);
        stk_wdata   = top_reg;

        if (ovalid_reg && m_axis_tready) begin
            ovalid_next = 1'b0;
        end

        unique case (st_reg)
            S_IDLE: begin
                act_raddr = {top_reg, in_sym};
                if (s_acc) begin
                    res_next  = '{ev: EV_ACK, nt: '0, rule: '0, top: top_vis, last: 1'b1};
                    red_next  = '0;
                    unique case (in_cmd)
                        CMD_ACT, CMD_RULE: begin
                            ovalid_next = 1'b1;
                        end
                        CMD_START: begin
                            stk_we      = 1'b1;
                            stk_waddr   = '0;
                            stk_wdata   = '0;
                            cnt_next    = CNTW'(1);
                            top_next    = '0;
                            ps_next     = PS_RUN;
                            res_next.top = '0;
                            ovalid_next = 1'b1;
                        end
                        default: begin
                            res_next.ev = EV_SYNTAX;
                            if (ps_reg != PS_RUN) begin
                                ovalid_next = 1'b1;
                            end else if (in_rej) begin
                                ps_next     = PS_FAIL;
                                ovalid_next = 1'b1;
                            end else begin
                                st_next = S_ACT;
                            end
                        end
                    endcase
                end
            end
            S_ACT: begin
                res_next = '{ev: EV_SYNTAX, nt: '0, rule: '0, top: top_vis, last: 1'b1};
                st_next  = S_OUT;
                if (act_rdata.kind == K_SHIFT) begin
                    if (cnt_reg >= CNTW'(STACK_DEPTH)) begin
                        res_next.ev = EV_FAULT;
                        ps_next     = PS_FAIL;
                    end else begin
                        stk_we      = 1'b1;
                        stk_wdata   = act_rdata.num;
                        cnt_next    = cnt_reg + 1'b1;
                        top_next    = act_rdata.num;
                        res_next.ev = EV_SHIFTED;
                        res_next.top = act_rdata.num;
                    end
                end else if (act_rdata.kind == K_REDUCE) begin
                    if (red_reg >= REDW'(MAX_REDUCTIONS)) begin
                        res_next.ev = EV_FAULT;
                        ps_next     = PS_FAIL;
                    end else begin
                        rule_raddr = act_rdata.num;
                        st_next    = S_RULE;
                    end
                end else if (act_rdata.kind == K_ACCEPT) begin
                    res_next.ev = EV_ACCEPTED;
                    ps_next     = PS_DONE;
                end else begin
                    ps_next = PS_FAIL;
                end
                if (st_next == S_OUT) begin
                    ovalid_next = 1'b1;
                    st_next     = S_IDLE;
                end
            end
            S_RULE: begin
                // rent_reg loaded this cycle; read new top below
                if (CNTW'(rule_rdata.len) >= cnt_reg) begin
                    res_next = '{ev: EV_FAULT, nt: '0, rule: '0, top: top_vis, last: 1'b1};
                    ps_next     = PS_FAIL;
                    ovalid_next = 1'b1;
                    st_next     = S_IDLE;
                end else begin
                    stk_raddr = SPW'(cnt_reg - CNTW'(rule_rdata.len) - 1'b1);
                    st_next   = S_TOP;
                end
            end
            S_TOP: begin
                // stk_rdata: exposed top after pop
                cnt_next  = cnt_pop;
                top_next  = stk_rdata;
                act_raddr = {stk_rdata, rent_reg.nt};
                st_next   = S_GOTO;
            end
            S_GOTO: begin
                if (act_rdata.kind != K_GOTO) begin
                    res_next = '{ev: EV_SYNTAX, nt: '0, rule: '0, top: top_vis, last: 1'b1};
                    ps_next     = PS_FAIL;
                    ovalid_next = 1'b1;
                    st_next     = S_IDLE;
                end else if (cnt_reg >= CNTW'(STACK_DEPTH)) begin
                    res_next = '{ev: EV_FAULT, nt: '0, rule: '0, top: top_vis, last: 1'b1};
                    ps_next     = PS_FAIL;
                    ovalid_next = 1'b1;
                    st_next     = S_IDLE;
                end else begin
                    stk_we    = 1'b1;
                    stk_wdata = act_rdata.num;
                    cnt_next  = cnt_reg + 1'b1;
                    top_next  = act_rdata.num;
                    red_next  = red_reg + 1'b1;
                    res_next  = '{ev: EV_REDUCED, nt: rent_reg.nt, rule: num_hold_reg.num,
                                  top: act_rdata.num, last: 1'b0};
                    ovalid_next = 1'b1;
                    st_next     = S_OUT;
                end
            end
            S_OUT: begin
                // wait for the reduction result to leave, then look up again
                act_raddr = {top_reg, sym_reg};
                if (!ovalid_reg || m_axis_tready) begin
                    st_next = S_ACT;
                end
            end
            default: begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg     <= S_IDLE;
            ps_reg     <= PS_IDLE;
            cnt_reg    <= '0;
            red_reg    <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            st_reg     <= st_next;
            ps_reg     <= ps_next;
            cnt_reg    <= cnt_next;
            red_reg    <= red_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        top_reg <= top_next;
        res_reg <= res_next;
        if (s_acc) begin
            sym_reg <= in_sym;
        end
        if (st_reg == S_ACT) begin
            num_hold_reg <= act_rdata;
        end
        if (st_reg == S_RULE) begin
            rent_reg <= rule_rdata;
        end
    end

    // at most a full stack
    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNTW'(STACK_DEPTH))
        else $error("stack count beyond depth");
    // reduction chain never exceeds its limit
    assert property (@(posedge aclk) disable iff (!aresetn)
        red_reg <= REDW'(MAX_REDUCTIONS))
        else $error("reduction counter overrun");
    // no new item while a result is pending or work is under way
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready |-> (st_reg == S_IDLE && !ovalid_reg))
        else $error("ready while busy");
    // a reduction result is never the last of its item
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser == EV_REDUCED) |-> !m_axis_tlast)
        else $error("reduction flagged last");
endmodule

FILE: sv/lrp_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module lrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: tb/sv/lr_shift_reduce_parse_engine_test.sv
// Self-checking testbench for lr_shift_reduce_parse_engine: drives commands on s_axis,
// predicts every m_axis result in a behavioral parse model and compares field by field.
// Depends on lrp_pkg and the engine RTL.
`timescale 1ns / 100ps

module lr_shift_reduce_parse_engine_test
    import lrp_pkg::*;
();

    // input item: cmd goes on s_axis_tuser, the low 56 bits line up with s_axis_tdata
    typedef struct packed {
        logic [1:0]     cmd;
        logic [5:0]     pad;
        logic           rej;
        logic [SYW-1:0] tok;
        logic [3:0]     rlen;
        logic [SYW-1:0] rnt;
        logic [RLW-1:0] ridx;
        logic [STW-1:0] num;
        logic [2:0]     kind;
        logic [SYW-1:0] sym;
        logic [STW-1:0] st;
    } cmd_item_t;

    localparam int CYCLE_LIMIT = 600000;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    lr_shift_reduce_parse_engine dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    // parser image: tables, stack and status, plus which entries were written
    logic [10:0]    act_tab [ACT_DEPTH];
    bit             act_written [ACT_DEPTH];
    logic [9:0]     rule_tab [RULE_COUNT];
    bit             rule_written [RULE_COUNT];
    logic [STW-1:0] stk [STACK_DEPTH];
    int             depth;
    logic [1:0]     pstat;

    result_t pending_events [$];
    int      mismatches;
    int      cycles;
    bit      idle_en;
    int      hold_len, hold_go, hold_seen, hold_left, stall_left;

    always begin
        aclk = 1'b1; #5;
        aclk = 1'b0; #5;
    end

    function automatic void add_event(ref result_t q[$], input logic [2:0] ev,
                                      input logic [SYW-1:0] nt, input logic [RLW-1:0] rl,
                                      input logic [STW-1:0] top);
        result_t r;
        r.ev = ev; r.nt = nt; r.rule = rl; r.top = top; r.last = 1'b0;
        q.push_back(r);
    endfunction

    // Walks a token through the image on local copies. Returns 0 without changing
    // anything if the walk would read a table entry that was never written.
    function automatic bit predict_token(input logic [SYW-1:0] tok, input logic rej);
        result_t        evs [$];
        logic [STW-1:0] s [STACK_DEPTH];
        int             c, reds, idx;
        logic [1:0]     ps;
        logic [10:0]    act, g;
        logic [9:0]     rent;
        logic [STW-1:0] top;
        bit             done;
        s = stk; c = depth; ps = pstat; reds = 0; done = 0;
        top = (c == 0) ? '0 : s[c-1];
        if (ps != PS_RUN) begin
            add_event(evs, EV_SYNTAX, '0, '0, top);
            done = 1;
        end else if (rej) begin
            ps = PS_FAIL;
            add_event(evs, EV_SYNTAX, '0, '0, top);
            done = 1;
        end
        while (!done) begin
            top = (c == 0) ? '0 : s[c-1];
            idx = int'({top, tok});
            if (!act_written[idx]) return 0;
            act = act_tab[idx];
            if (act[10:8] == K_SHIFT) begin
                if (c >= STACK_DEPTH) begin
                    ps = PS_FAIL;
                    add_event(evs, EV_FAULT, '0, '0, top);
                end else begin
                    s[c] = act[7:0]; c++;
                    add_event(evs, EV_SHIFTED, '0, '0, act[7:0]);
                end
                done = 1;
            end else if (act[10:8] == K_REDUCE) begin
                if (!rule_written[act[7:0]]) return 0;
                rent = rule_tab[act[7:0]];
                if (reds >= MAX_REDUCTIONS || int'(rent[3:0]) >= c) begin
                    ps = PS_FAIL;
                    add_event(evs, EV_FAULT, '0, '0, top);
                    done = 1;
                end else begin
                    c -= int'(rent[3:0]);
                    top = (c == 0) ? '0 : s[c-1];
                    idx = int'({top, rent[9:4]});
                    if (!act_written[idx]) return 0;
                    g = act_tab[idx];
                    if (g[10:8] != K_GOTO) begin
                        ps = PS_FAIL;
                        add_event(evs, EV_SYNTAX, '0, '0, top);
                        done = 1;
                    end else begin
                        // c >= 1 here since len < c before the pop
                        s[c] = g[7:0]; c++;
                        add_event(evs, EV_REDUCED, rent[9:4], act[7:0], g[7:0]);
                        reds++;
                    end
                end
            end else if (act[10:8] == K_ACCEPT) begin
                ps = PS_DONE;
                add_event(evs, EV_ACCEPTED, '0, '0, top);
                done = 1;
            end else begin
                // error entry, goto entries and unused kind codes
                ps = PS_FAIL;
                add_event(evs, EV_SYNTAX, '0, '0, top);
                done = 1;
            end
        end
        evs[$].last = 1'b1;
        stk = s; depth = c; pstat = ps;
        foreach (evs[i]) pending_events.push_back(evs[i]);
        return 1;
    endfunction

    function automatic bit predict_command(input cmd_item_t it);
        result_t        evs [$];
        logic [STW-1:0] top;
        top = (depth == 0) ? '0 : stk[depth-1];
        case (it.cmd)
            CMD_ACT: begin
                act_tab[{it.st, it.sym}] = {it.kind, it.num};
                act_written[{it.st, it.sym}] = 1;
                add_event(evs, EV_ACK, '0, '0, top);
            end
            CMD_RULE: begin
                rule_tab[it.ridx] = {it.rnt, it.rlen};
                rule_written[it.ridx] = 1;
                add_event(evs, EV_ACK, '0, '0, top);
            end
            CMD_START: begin
                stk[0] = '0; depth = 1; pstat = PS_RUN;
                add_event(evs, EV_ACK, '0, '0, '0);
            end
            default: return predict_token(it.tok, it.rej);
        endcase
        evs[0].last = 1'b1;
        pending_events.push_back(evs[0]);
        return 1;
    endfunction

    // Shared sender: entered and left at a falling edge. Sends only if the
    // model could predict the command without touching unwritten entries.
    task automatic send_item(input cmd_item_t it, output bit sent);
        sent = predict_command(it);
        if (!sent) return;
        s_axis_tdata  = it[55:0];
        s_axis_tuser  = it.cmd;
        s_axis_tvalid = 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        @(negedge aclk);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
    endtask

    function automatic cmd_item_t noise_item(input logic [1:0] cmd);
        cmd_item_t   it;
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        it = raw[57:0];
        it.pad = '0;
        it.cmd = cmd;
        return it;
    endfunction

    task automatic put_action(input int st, input int sym, input logic [2:0] kind,
                              input int num);
        cmd_item_t it;
        bit ok;
        it = noise_item(CMD_ACT);
        it.st = STW'(st); it.sym = SYW'(sym); it.kind = kind; it.num = STW'(num);
        send_item(it, ok);
    endtask

    task automatic put_rule(input int idx, input int nt, input int len);
        cmd_item_t it;
        bit ok;
        it = noise_item(CMD_RULE);
        it.ridx = RLW'(idx); it.rnt = SYW'(nt); it.rlen = 4'(len);
        send_item(it, ok);
    endtask

    task automatic start_parse();
        bit ok;
        send_item(noise_item(CMD_START), ok);
    endtask

    task automatic feed_token(input int tok, input logic rej, output bit ok);
        cmd_item_t it;
        it = noise_item(CMD_TOKEN);
        it.tok = SYW'(tok); it.rej = rej;
        send_item(it, ok);
    endtask

    task automatic report_mismatch(input string what, input result_t got, input result_t want);
        $display("mismatch %s: got %0d/%0d/%0d/%0d/%0d want %0d/%0d/%0d/%0d/%0d",
                 what, got.ev, got.nt, got.rule, got.top, got.last,
                 want.ev, want.nt, want.rule, want.top, want.last);
        mismatches++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid = 1'b0;
        while (pending_events.size() != 0) @(negedge aclk);
    endtask

    // result checker, sampled at the rising edge
    always @(posedge aclk) begin
        result_t got, want;
        cycles <= cycles + 1;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tuser, m_axis_tdata[5:0], m_axis_tdata[13:6],
                   m_axis_tdata[21:14], m_axis_tlast};
            if (pending_events.size() == 0) begin
                report_mismatch("unexpected transaction", got, got);
            end else begin
                want = pending_events.pop_front();
                if (got.ev != want.ev)     report_mismatch("event_res", got, want);
                if (got.nt != want.nt)     report_mismatch("reduced_nonterminal", got, want);
                if (got.rule != want.rule) report_mismatch("reduced_rule", got, want);
                if (got.top != want.top)   report_mismatch("top_state", got, want);
                if (got.last != want.last) report_mismatch("tlast", got, want);
            end
        end
    end

    always @(posedge aclk) begin
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result sink: random stall bursts, plus a long hold-off on request
    always @(negedge aclk) begin
        if (hold_go != hold_seen) begin
            hold_seen = hold_go;
            hold_left = hold_len;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 3);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // tokens outside a parse, field extremes, odd kind codes
    task automatic test_loads_and_idle_tokens();
        bit ok;
        feed_token(63, 1'b0, ok);
        feed_token(0, 1'b1, ok);
        put_action(255, 63, 3'd7, 255);
        put_action(0, 0, 3'd0, 0);
        put_rule(255, 63, 15);
        put_rule(0, 0, 0);
    endtask

    // every action kind and the missing-goto and underflow paths of a reduction
    task automatic test_actions();
        bit ok;
        put_rule(1, 2, 0);             // empty rule producing nt 2
        put_rule(2, 6, 0);             // goto column 6 holds a shift: missing goto
        put_rule(3, 9, 1);             // pops the only state: underflow
        put_action(0, 2, K_GOTO, 5);
        put_action(5, 10, K_SHIFT, 7);
        put_action(0, 10, K_REDUCE, 1);
        put_action(7, 11, K_ACCEPT, 0);
        put_action(0, 6, K_SHIFT, 1);
        put_action(0, 7, K_REDUCE, 2);
        put_action(0, 8, K_REDUCE, 3);
        put_action(0, 9, 3'd5, 0);
        start_parse();
        feed_token(10, 1'b0, ok);      // reduce then shift
        feed_token(11, 1'b0, ok);      // accept
        feed_token(10, 1'b0, ok);      // token after accept
        start_parse();
        feed_token(7, 1'b0, ok);
        start_parse();
        feed_token(8, 1'b0, ok);
        start_parse();
        feed_token(9, 1'b0, ok);
        start_parse();
        feed_token(10, 1'b1, ok);      // scanner reject inside a parse
    endtask

    // endless empty-rule loop hits the reduction limit; receiver holds off meanwhile
    task automatic test_reduction_limit();
        bit ok;
        put_rule(4, 3, 0);
        put_action(0, 3, K_GOTO, 0);
        put_action(0, 12, K_REDUCE, 4);
        start_parse();
        hold_len = 400;
        hold_go++;
        feed_token(12, 1'b0, ok);
        start_parse();
        feed_token(12, 1'b0, ok);
        wait_drained();
    endtask

    // shifting state 0 onto itself until the stack is full
    task automatic test_stack_overflow();
        bit ok;
        put_action(0, 13, K_SHIFT, 0);
        start_parse();
        repeat (STACK_DEPTH) feed_token(13, 1'b0, ok);
        wait_drained();
    endtask

    function automatic logic [2:0] pick_kind();
        int r;
        r = $urandom_range(0, 19);
        if (r < 6)  return K_SHIFT;
        if (r < 12) return K_REDUCE;
        if (r < 16) return K_GOTO;
        if (r < 18) return K_ACCEPT;
        return (r == 18) ? 3'd0 : 3'($urandom_range(5, 7));
    endfunction

    // small closed grammar on states and symbols 0..7 so random tokens parse deeply
    task automatic test_grammar_fill();
        for (int st = 0; st < 8; st++)
            for (int sym = 0; sym < 8; sym++)
                put_action(st, sym, pick_kind(), $urandom_range(0, 7));
        for (int r = 0; r < 8; r++)
            put_rule(r, $urandom_range(0, 7), $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 2));
    endtask

    task automatic test_random_parses(input int count);
        cmd_item_t it;
        bit ok;
        int sel, tries;
        for (int n = 0; n < count; n++) begin
            if (n == count - 60) idle_en = 0;
            sel = $urandom_range(0, 99);
            if (pstat != PS_RUN && sel < 60) sel = 80;
            if (sel < 72) begin
                ok = 0;
                for (tries = 0; tries < 8 && !ok; tries++)
                    feed_token($urandom_range(0, 9) == 0 ? $urandom_range(0, 63)
                                                          : $urandom_range(0, 7),
                               $urandom_range(0, 15) == 0, ok);
                if (!ok) start_parse();
            end else if (sel < 84) begin
                start_parse();
            end else if (sel < 92) begin
                put_action($urandom_range(0, 7), $urandom_range(0, 7), pick_kind(),
                           $urandom_range(0, 7));
            end else if (sel < 96) begin
                put_rule($urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 2));
            end else begin
                // full-range writes keep every field bit moving
                it = noise_item(($urandom_range(0, 1) == 0) ? CMD_ACT : CMD_RULE);
                send_item(it, ok);
            end
            if (n == count / 2) wait_drained();
        end
    endtask

    initial begin
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        depth = 0; pstat = PS_IDLE;
        mismatches = 0; idle_en = 1;
        hold_len = 0; hold_go = 0;
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_loads_and_idle_tokens();
        test_actions();
        test_reduction_limit();
        test_stack_overflow();
        test_grammar_fill();
        test_random_parses(220);

        s_axis_tvalid = 1'b0;
        wait_drained();
        repeat (50) @(posedge aclk);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
